>>> src/rswpd_pkg.sv
// Shared types and constants for the RGB sliding-window pulse density modulator.
package rswpd_pkg;

	localparam int WindowBits = 8;
	localparam int CntW       = $clog2(WindowBits + 1);
	localparam int LevelW     = 18;
	localparam int FracW      = 16;
	localparam int NumChan    = 3;

	// Level one and the rounding half, in Q1.16
	localparam logic [FracW:0] LevelOne = (FracW + 1)'(1) << FracW;
	localparam logic [FracW:0] HalfQ16  = (FracW + 1)'(1) << (FracW - 1);

	typedef logic signed [LevelW-1:0] level_t;
	typedef logic [WindowBits-1:0]    win_t;
	typedef logic [CntW-1:0]          cnt_t;

endpackage

>>> src/rswpd_level_if.sv
// Channel carrying one tick of three signed Q1.16 colour levels.
interface rswpd_level_if;

	logic                   valid;
	logic                   ready;
	rswpd_pkg::level_t      red_level;
	rswpd_pkg::level_t      green_level;
	rswpd_pkg::level_t      blue_level;

	modport source (output valid, red_level, green_level, blue_level, input ready);
	modport sink   (input valid, red_level, green_level, blue_level, output ready);

endinterface

>>> src/rswpd_drive_if.sv
// Channel carrying one tick of three LED drive bits.
interface rswpd_drive_if;

	logic valid;
	logic ready;
	logic red_on;
	logic green_on;
	logic blue_on;

	modport source (output valid, red_on, green_on, blue_on, input ready);
	modport sink   (input valid, red_on, green_on, blue_on, output ready);

endinterface

>>> src/rgb_sliding_window_pulse_density_core.sv
// Top level: three-channel sliding-window pulse density modulator.
//
//  channel | dir | payload                               | handshake
//  levels  | in  | red/green/blue_level, signed Q1.16    | valid/ready
//  drive   | out | red/green/blue_on, one bit each       | valid/ready
//
// One transaction per cycle sustained while drive.ready holds; each passes
// the input register, then modulator logic into the result register.
// The window history and ones count of each channel advance as a
// transaction moves from the input register to the result register.
// arst_n clears histories, counts and both valid flags.
// A stalled result register holds; the input register still takes a new
// transaction while the result waits, then stalls behind it.
module rgb_sliding_window_pulse_density_core (
	input  logic          clk,
	input  logic          arst_n,
	rswpd_level_if.sink   levels,
	rswpd_drive_if.source drive
);

	localparam int SumW = rswpd_pkg::FracW + 1 + rswpd_pkg::CntW + 1;

	// target = round_half_up(clamp(level) * N)
	function automatic rswpd_pkg::cnt_t level_target(input rswpd_pkg::level_t lvl);
		logic [rswpd_pkg::FracW:0] mag;
		logic [SumW-1:0]           sum;
		if (lvl[rswpd_pkg::LevelW-1]) begin
			mag = '0;
		end else if (lvl[rswpd_pkg::FracW:0] > rswpd_pkg::LevelOne) begin
			mag = rswpd_pkg::LevelOne;
		end else begin
			mag = lvl[rswpd_pkg::FracW:0];
		end
		sum = SumW'(mag) * SumW'(rswpd_pkg::WindowBits) + SumW'(rswpd_pkg::HalfQ16);
		return rswpd_pkg::CntW'(sum >> rswpd_pkg::FracW);
	endfunction

	rswpd_pkg::level_t lvl_s1 [rswpd_pkg::NumChan];
	logic              valid_s1;
	logic              on_s2  [rswpd_pkg::NumChan];
	logic              valid_s2;

	rswpd_pkg::win_t   hist_q [rswpd_pkg::NumChan];
	rswpd_pkg::cnt_t   cnt_q  [rswpd_pkg::NumChan];

	rswpd_pkg::cnt_t   target [rswpd_pkg::NumChan];
	logic              leaving[rswpd_pkg::NumChan];
	logic              bit_new[rswpd_pkg::NumChan];
	rswpd_pkg::cnt_t   cnt_nxt[rswpd_pkg::NumChan];

	logic load_s2;
	logic load_s1;

	assign load_s2      = valid_s1 && (!valid_s2 || drive.ready);
	assign load_s1      = levels.valid && levels.ready;
	assign levels.ready = !valid_s1 || load_s2;

	always_comb begin
		for (int c = 0; c < rswpd_pkg::NumChan; c++) begin
			target[c]  = level_target(lvl_s1[c]);
			leaving[c] = hist_q[c][rswpd_pkg::WindowBits-1];
			if (target[c] > cnt_q[c]) begin
				bit_new[c] = 1'b1;
			end else if (target[c] < cnt_q[c]) begin
				bit_new[c] = 1'b0;
			end else begin
				bit_new[c] = leaving[c];   // tie: keep the density steady
			end
			cnt_nxt[c] = rswpd_pkg::CntW'(cnt_q[c] - rswpd_pkg::CntW'(leaving[c])
				+ rswpd_pkg::CntW'(bit_new[c]));
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (levels.ready) begin
			valid_s1 <= levels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			lvl_s1[0] <= levels.red_level;
			lvl_s1[1] <= levels.green_level;
			lvl_s1[2] <= levels.blue_level;
		end
	end

	// Result register and modulator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			for (int c = 0; c < rswpd_pkg::NumChan; c++) begin
				hist_q[c] <= '0;
				cnt_q[c]  <= '0;
			end
		end else begin
			if (!valid_s2 || drive.ready) begin
				valid_s2 <= valid_s1;
			end
			if (load_s2) begin
				for (int c = 0; c < rswpd_pkg::NumChan; c++) begin
					hist_q[c] <= {hist_q[c][rswpd_pkg::WindowBits-2:0], bit_new[c]};
					cnt_q[c]  <= cnt_nxt[c];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			for (int c = 0; c < rswpd_pkg::NumChan; c++) begin
				on_s2[c] <= bit_new[c];
			end
		end
	end

	assign drive.valid    = valid_s2;
	assign drive.red_on   = on_s2[0];
	assign drive.green_on = on_s2[1];
	assign drive.blue_on  = on_s2[2];

	// The running count must track the ones held in each window
	a_red_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[0] == rswpd_pkg::CntW'($countones(hist_q[0])))
		else $error("red ones count out of step with window");

	a_green_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[1] == rswpd_pkg::CntW'($countones(hist_q[1])))
		else $error("green ones count out of step with window");

	a_blue_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[2] == rswpd_pkg::CntW'($countones(hist_q[2])))
		else $error("blue ones count out of step with window");

	// A transaction leaving the input register lands in the result register
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("advanced transaction lost before result register");

	// Window state moves only when a transaction advances
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!load_s2 |=> $stable(cnt_q[0]) && $stable(cnt_q[1]) && $stable(cnt_q[2]))
		else $error("window count changed without a transaction");

endmodule
